>>> src/sha_pkg.sv
// Shared types, constants and the round constant table of the SHA-256 compression block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package sha_pkg;

  localparam int WordW  = 32;
  localparam int IdxW   = 3;
  localparam int Digest = 8;
  localparam int Block  = 16;
  localparam int PosW   = $clog2(Block);
  localparam int Rounds = 64;
  localparam int RndW   = $clog2(Rounds);

  // Queue between the front and the back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Input command codes.
  localparam logic CMD_MSG  = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic {
    ITEM_MSG,
    ITEM_LOAD
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic              blk_end;
    logic [WordW-1:0]  data;
    logic [IdxW-1:0]   idx;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } back_state_t;

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] t);
    logic [WordW-1:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> src/sha_front.sv
// Front end: accepts input transactions, tags each one and pushes it into the queue.
// Depends on sha_pkg.
`default_nettype none
module sha_front
  import sha_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  input  wire logic [WordW-1:0]  in_data_word,
  input  wire logic [IdxW-1:0]   in_load_index,
  input  wire q_status_t         q_status,
  output logic                   push,
  output item_t                  push_item
);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            is_load;

  assign is_load  = (in_cmd == CMD_LOAD);
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // The sixteenth message word of a block is marked so the back end knows to compress.
  always_comb begin
    push_item.kind    = is_load ? ITEM_LOAD : ITEM_MSG;
    push_item.blk_end = !is_load && (pos_r == PosW'(Block - 1));
    push_item.data    = in_data_word;
    push_item.idx     = in_load_index;
    pos_nxt = pos_r;
    if (push && !is_load) begin
      pos_nxt = pos_r + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/sha_queue.sv
// Short FIFO of tagged transactions between the front end and the back end.
// Depends on sha_pkg.
`default_nettype none
module sha_queue
  import sha_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire item_t  push_item,
  input  wire logic   pop,
  output q_status_t   q_status,
  output item_t       head_item
);

  item_t              mem_r [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_status.valid = (cnt_r != '0);
  assign q_status.full  = (cnt_r == QCntW'(QDepth));
  assign head_item      = mem_r[rd_ptr_r];
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && q_status.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> src/sha_back.sv
// Back end: digest loads, message schedule, one round per cycle, feed-forward and output.
// Depends on sha_pkg.
`default_nettype none
module sha_back
  import sha_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_status_t         q_status,
  input  wire item_t             head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WordW-1:0]       out_digest_word,
  output logic [IdxW-1:0]        out_digest_index,
  output logic                   out_last
);

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  back_state_t      state_r, state_nxt;
  logic [WordW-1:0] h_r [Digest];
  logic [WordW-1:0] h_nxt [Digest];
  logic [WordW-1:0] v_r [Digest];
  logic [WordW-1:0] v_nxt [Digest];
  logic [WordW-1:0] w_r [Block];
  logic [WordW-1:0] w_nxt [Block];
  logic [RndW-1:0]  rnd_r, rnd_nxt;
  logic [IdxW-1:0]  oidx_r, oidx_nxt;

  logic [WordW-1:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new;

  // Round and schedule datapath.
  always_comb begin
    big1  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + ch + round_k(rnd_r) + w_r[0];
    big0  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = big0 + maj;
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    h_nxt     = h_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_status.valid) begin
          pop = 1'b1;
          if (head_item.kind == ITEM_LOAD) begin
            h_nxt[head_item.idx] = head_item.data;
          end else begin
            for (int i = 0; i < Block - 1; i++) begin
              w_nxt[i] = w_r[i+1];
            end
            w_nxt[Block-1] = head_item.data;
            if (head_item.blk_end) begin
              v_nxt     = h_r;
              rnd_nxt   = '0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < Block - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[Block-1] = w_new;
        rnd_nxt = rnd_r + RndW'(1);
        if (rnd_r == RndW'(Rounds - 1)) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < Digest; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        oidx_nxt  = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          oidx_nxt = oidx_r + IdxW'(1);
          if (oidx_r == IdxW'(Digest - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_digest_word  = h_r[oidx_r];
  assign out_digest_index = oidx_r;
  assign out_last         = (oidx_r == IdxW'(Digest - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < Digest; i++) begin
        h_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

endmodule
`default_nettype wire

>>> src/sha256_block_compression.sv
// Top level of the SHA-256 block compression engine: front end, queue and back end.
// Depends on sha_pkg, sha_front, sha_queue and sha_back.
//
//   Channel  Handshake             Payload
//   in_      in_valid / in_stall   in_cmd, in_data_word, in_load_index
//   out_     out_valid / out_stall out_digest_word, out_digest_index, out_last
//
// A block of sixteen message words goes through these steps: the back end takes
// each queued transaction, runs 64 rounds (one round per cycle through the shared
// round datapath), adds the feed-forward and presents the eight digest words.
// Reset is synchronous and active low; it clears the
// chaining digest to zero, empties the queue and restarts the word position.
// The four-entry queue keeps taking input transactions until it is full while
// the back end is compressing or while results wait on out_stall.
`default_nettype none
module sha256_block_compression
  import sha_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  input  wire logic [WordW-1:0]  in_data_word,
  input  wire logic [IdxW-1:0]   in_load_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WordW-1:0]       out_digest_word,
  output logic [IdxW-1:0]        out_digest_index,
  output logic                   out_last
);

  q_status_t q_status;
  item_t     push_item;
  item_t     head_item;
  logic      push;
  logic      pop;

  // The front end tags each transaction as a load or a message word and marks
  // the word that completes a block.
  sha_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_data_word  (in_data_word),
    .in_load_index (in_load_index),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  // Transactions are held in order so a load that follows a block's last word
  // only takes effect after that block's digest has been sent.
  sha_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_status  (q_status),
    .head_item (head_item)
  );

  // The back end runs the compression and presents the eight digest words.
  sha_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_digest_index (out_digest_index),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

>>> src/sha_checker.sv
// Port-level checks of the SHA-256 compression top level, attached by a bind.
// Depends on sha_pkg and the top level sha256_block_compression.
`default_nettype none
module sha_checker
  import sha_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_cmd,
  input wire logic [WordW-1:0]  in_data_word,
  input wire logic [IdxW-1:0]   in_load_index,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [WordW-1:0]  out_digest_word,
  input wire logic [IdxW-1:0]   out_digest_index,
  input wire logic              out_last
);

  // A stalled input transaction stays on the bus unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_cmd) && $stable(in_data_word) &&
      $stable(in_load_index))
    else $error("stalled input transaction changed");

  // A stalled result holds its position and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_index) &&
      $stable(out_digest_word) && $stable(out_last))
    else $error("stalled digest word changed");

  // The eight digest words of a run follow each other without a gap.
  a_run_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_digest_index == $past(out_digest_index) + 3'd1))
    else $error("digest run broken or out of order");

  // The last flag marks exactly the word h.
  a_last_h: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_digest_index == IdxW'(Digest - 1))))
    else $error("last flag does not match digest index");

  // No result is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented after reset");

endmodule

bind sha256_block_compression sha_checker u_sha_checker (.*);
`default_nettype wire
